// ===== design/clc_pkg.sv =====
package clc_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIRST  = 2'd1,
      CMD_NEXT   = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_END   = 2'd2,
      ST_NOCUR = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] data_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data_out;
      logic [7:0]         entry_count;
   } rsp_type;

   // per-cell control: load, shift and read select
   typedef struct packed {
      logic load;
      logic shift;
      logic sel;
   } cell_ctl_type;

endpackage

// ===== design/compacting_list_with_cursor.sv =====
// Ordered list of up to DEPTH signed 32-bit entries with one read cursor, held in a
// row of cells, one entry per cell. Every command (insert, first, next, remove) has
// its result registered into the output register when it is accepted,
// so one item per cycle is sustained while rsp_ready stays high; the rate is
// set by the cell row, which loads, shifts down or reads all cells at once.
// Remove closes the gap by shifting every later cell toward the head in that same
// cycle. No clearing pass follows reset: entries are only read once written.
module compacting_list_with_cursor #(
   parameter int DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  clc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output clc_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   // cursor plus one: zero means no position
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   clc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             insert_ok, first_ok, next_ok, remove_ok;
   logic [CNT_W-1:0] rd_pos;
   logic [CNT_W+7:0] cnt_ext;
   logic signed [31:0] rd_or;
   clc_pkg::status_type status;

   clc_pkg::cell_ctl_type ctl     [DEPTH];
   logic signed [31:0]    cell_val[DEPTH];
   logic signed [31:0]    cell_rd [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      insert_ok = 1'b0;
      first_ok  = 1'b0;
      next_ok   = 1'b0;
      remove_ok = 1'b0;
      rd_pos    = '0;
      status    = clc_pkg::ST_OK;
      case (req_data.cmd)
         clc_pkg::CMD_INSERT: begin
            insert_ok = accept && (count_ff < CNT_W'(DEPTH));
            if (count_ff >= CNT_W'(DEPTH)) status = clc_pkg::ST_FULL;
         end
         clc_pkg::CMD_FIRST: begin
            first_ok = accept && (count_ff != '0);
            rd_pos   = '0;
            if (count_ff == '0) status = clc_pkg::ST_END;
         end
         clc_pkg::CMD_NEXT: begin
            next_ok = accept && (pos_ff < count_ff);
            rd_pos  = pos_ff;
            if (pos_ff >= count_ff) status = clc_pkg::ST_END;
         end
         clc_pkg::CMD_REMOVE: begin
            remove_ok = accept && (pos_ff != '0) && (pos_ff <= count_ff);
            rd_pos    = pos_ff - CNT_W'(1);
            if ((pos_ff == '0) || (pos_ff > count_ff)) status = clc_pkg::ST_NOCUR;
         end
         default: begin
            status = clc_pkg::ST_OK;
         end
      endcase
   end

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] next_data;

      if (i == DEPTH - 1) begin : g_tail
         assign next_data = 32'sd0;
      end else begin : g_body
         assign next_data = cell_val[i+1];
      end

      assign ctl[i].load  = insert_ok && (count_ff == CNT_W'(i));
      assign ctl[i].shift = remove_ok && (CNT_W'(i) >= rd_pos)
                            && (CNT_W'(i + 1) < count_ff);
      assign ctl[i].sel   = (CNT_W'(i) == rd_pos);

      clc_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[i]),
         .load_data (req_data.data_in),
         .next_data (next_data),
         .value     (cell_val[i]),
         .rd_data   (cell_rd[i])
      );
   end

   always_comb begin
      rd_or = 32'sd0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (insert_ok) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (first_ok) begin
         pos_in = CNT_W'(1);
      end
      if (next_ok) begin
         pos_in = pos_ff + CNT_W'(1);
      end
      if (remove_ok) begin
         count_in = count_ff - CNT_W'(1);
         pos_in   = pos_ff - CNT_W'(1);
      end
   end

   assign cnt_ext = {8'd0, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = status;
         rsp_data_in.data_out     = (first_ok || next_ok || remove_ok) ? rd_or : 32'sd0;
         rsp_data_in.entry_count  = cnt_ext[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/clc_cell.sv =====
module clc_cell (
   input  logic                      clock,
   input  clc_pkg::cell_ctl_type     ctl,
   input  logic signed [31:0]        load_data,
   input  logic signed [31:0]        next_data,
   output logic signed [31:0]        value,
   output logic signed [31:0]        rd_data
);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   // load wins over shift; the two never coincide in the same cycle
   always_comb begin
      if (ctl.load) begin
         entry_in = load_data;
      end else if (ctl.shift) begin
         entry_in = next_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign value   = entry_ff;
   assign rd_data = ctl.sel ? entry_ff : 32'sd0;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int DEPTH      = 128;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_CNT = 1230;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   clc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   clc_pkg::rsp_type rsp_data;

   compacting_list_with_cursor #(.DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // list shadow used for prediction
   logic signed [31:0] list_words [DEPTH];
   int                 shadow_cnt = 0;
   int                 cursor_pos = -1;

   clc_pkg::req_type cmd_q [$];
   clc_pkg::rsp_type pending_rsp [$];

   int err_cnt   = 0;
   int n_ok      = 0;
   int n_full    = 0;
   int n_end     = 0;
   int n_nocur   = 0;
   int peak_len  = 0;
   int idle_cnt  = 0;

   function automatic clc_pkg::rsp_type list_apply(clc_pkg::req_type r);
      clc_pkg::rsp_type o;
      int               i;
      o.status   = clc_pkg::ST_OK;
      o.data_out = '0;
      case (r.cmd)
         clc_pkg::CMD_INSERT: begin
            if (shadow_cnt >= DEPTH) begin
               o.status = clc_pkg::ST_FULL;
            end else begin
               list_words[shadow_cnt] = r.data_in;
               shadow_cnt++;
            end
         end
         clc_pkg::CMD_FIRST: begin
            if (shadow_cnt == 0) begin
               o.status = clc_pkg::ST_END;
            end else begin
               cursor_pos = 0;
               o.data_out = list_words[0];
            end
         end
         clc_pkg::CMD_NEXT: begin
            if (cursor_pos >= shadow_cnt - 1) begin
               o.status = clc_pkg::ST_END;
            end else begin
               cursor_pos++;
               o.data_out = list_words[cursor_pos];
            end
         end
         default: begin
            if (cursor_pos < 0 || cursor_pos >= shadow_cnt) begin
               o.status = clc_pkg::ST_NOCUR;
            end else begin
               o.data_out = list_words[cursor_pos];
               // close the gap
               for (i = cursor_pos; i < shadow_cnt - 1; i++)
                  list_words[i] = list_words[i + 1];
               shadow_cnt--;
               cursor_pos--;
            end
         end
      endcase
      o.entry_count = shadow_cnt[7:0];
      return o;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_cmd(clc_pkg::cmd_type c, logic [31:0] d);
      clc_pkg::req_type r;
      r.cmd     = c;
      r.data_in = d;
      cmd_q.push_back(r);
   endtask

   // sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= cmd_q.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall on a rotating mask that is redrawn whenever rdy_age reaches its top value
   logic [7:0] rdy_mask  = 8'hff;
   logic [2:0] rdy_phase = '0;
   logic [7:0] rdy_age   = '0;

   always @(posedge clock) begin
      rdy_phase <= rdy_phase + 3'd1;
      rdy_age   <= rdy_age + 8'd1;
      rsp_ready <= rdy_mask[rdy_phase];
      if (rdy_age == 8'hff) begin
         case ($urandom_range(0, 3))
            0:       rdy_mask <= 8'hff;
            1:       rdy_mask <= 8'h11;
            2:       rdy_mask <= 8'hf0;
            default: rdy_mask <= 8'($urandom) | 8'h01;
         endcase
      end
   end

   // check results first, then predict the newly accepted item
   always @(posedge clock) begin
      clc_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("result with no command outstanding: %p", rsp_data);
               err_cnt++;
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %s, got %0d", e.status.name(), rsp_data.status);
                  err_cnt++;
               end
               if (rsp_data.data_out !== e.data_out) begin
                  $error("data_out: expected %0d, got %0d", e.data_out, rsp_data.data_out);
                  err_cnt++;
               end
               if (rsp_data.entry_count !== e.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         e.entry_count, rsp_data.entry_count);
                  err_cnt++;
               end
            end
         end
         if (req_valid && req_ready) begin
            e = list_apply(req_data);
            pending_rsp.push_back(e);
            case (e.status)
               clc_pkg::ST_OK:   n_ok++;
               clc_pkg::ST_FULL: n_full++;
               clc_pkg::ST_END:  n_end++;
               default:          n_nocur++;
            endcase
            if (shadow_cnt > peak_len)
               peak_len = shadow_cnt;
         end
      end
   end

   // watchdog on cycles with no traffic on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
         $display("hung: no item moved for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, pending_rsp.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int               n;
      int               seg_len;
      int               mode;
      int               roll;
      clc_pkg::cmd_type c;

      // empty list corners, extremes of data, cursor walk, refusals
      add_cmd(clc_pkg::CMD_NEXT,   $urandom);
      add_cmd(clc_pkg::CMD_FIRST,  $urandom);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_INSERT, 32'h8000_0000);
      add_cmd(clc_pkg::CMD_INSERT, 32'h7fff_ffff);
      add_cmd(clc_pkg::CMD_INSERT, 32'h0000_0000);
      add_cmd(clc_pkg::CMD_INSERT, 32'hffff_ffff);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_NEXT,   $urandom);
      add_cmd(clc_pkg::CMD_NEXT,   $urandom);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_FIRST,  $urandom);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_NEXT,   $urandom);
      add_cmd(clc_pkg::CMD_NEXT,   $urandom);
      add_cmd(clc_pkg::CMD_NEXT,   $urandom);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_INSERT, 32'h5555_aaaa);
      add_cmd(clc_pkg::CMD_NEXT,   $urandom);
      add_cmd(clc_pkg::CMD_FIRST,  $urandom);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_REMOVE, $urandom);
      add_cmd(clc_pkg::CMD_FIRST,  $urandom);

      // fill to capacity early so the full case is hit, then random segments
      for (int k = 0; k < 140; k++)
         add_cmd(clc_pkg::CMD_INSERT, pick_word());
      n = 140;
      while (n < RANDOM_CNT) begin
         seg_len = $urandom_range(20, 80);
         mode    = $urandom_range(0, 9);
         for (int k = 0; k < seg_len; k++) begin
            roll = $urandom_range(0, 99);
            if (mode < 4) begin          // fill
               c = (roll < 85) ? clc_pkg::CMD_INSERT :
                   clc_pkg::cmd_type'($urandom_range(1, 3));
            end else if (mode < 7) begin // drain
               c = (roll < 10) ? clc_pkg::CMD_FIRST : (roll < 40) ? clc_pkg::CMD_NEXT :
                   (roll < 95) ? clc_pkg::CMD_REMOVE : clc_pkg::CMD_INSERT;
            end else if (mode < 8) begin // scan
               c = (roll < 10) ? clc_pkg::CMD_FIRST : (roll < 90) ? clc_pkg::CMD_NEXT :
                   clc_pkg::cmd_type'($urandom_range(0, 3));
            end else begin
               c = clc_pkg::cmd_type'($urandom_range(0, 3));
            end
            add_cmd(c, pick_word());
         end
         n += seg_len;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() > 0 || req_valid || pending_rsp.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (pending_rsp.size() != 0) begin
         $error("%0d results never arrived", pending_rsp.size());
         err_cnt++;
      end
      $display("covered %0d commands: %0d ok, %0d full, %0d at end, %0d without entry",
               n_ok + n_full + n_end + n_nocur, n_ok, n_full, n_end, n_nocur);
      $display("list reached %0d of %0d entries; %0d mismatches", peak_len, DEPTH, err_cnt);
      if (err_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
